/* hw/rtl/line_segment_window_clipper_assert.svh */
// Assertion macros used by the segment clipper top level
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_ASSERT_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_ASSERT_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset
`define LSWC_ASSERT(lbl, ck, rn, pr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pr)) else $error(msg);
// Check that a condition implies another in the same cycle
`define LSWC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define LSWC_ASSERT(lbl, ck, rn, pr, msg)
`define LSWC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`endif
`endif

/* hw/rtl/lswc_pkg.sv */
// Types, constants and helper functions of the segment clipper
package lswc_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int QUO_BITS   = COORD_BITS;
	localparam int PROD_BITS  = 2 * MAG_BITS;
	localparam int REM_BITS   = 2 * COORD_BITS + 2;
	// per edge: setup, multiply, dividend, one stage per quotient bit, apply
	localparam int EDGE_LAT   = QUO_BITS + 4;
	// accept edge to the edge that takes the result; done rises at the edge before that
	localparam int LATENCY    = 4 * EDGE_LAT + 2;

	localparam int REG_IDX_BITS = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_CORNER_A_X = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_CORNER_A_Y = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_CORNER_B_X = 2'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_CORNER_B_Y = 2'd3;

	localparam logic signed [COORD_BITS-1:0] CORNER_A_RST = -COORD_BITS'(100);
	localparam logic signed [COORD_BITS-1:0] CORNER_B_RST = COORD_BITS'(100);

	typedef enum logic [1:0] {
		EDGE_LEFT   = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_BOTTOM = 2'd2,
		EDGE_TOP    = 2'd3
	} edge_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} seg_in_t;

	typedef struct packed {
		logic                         visible;
		logic                         clipped;
		logic signed [COORD_BITS-1:0] out_start_x;
		logic signed [COORD_BITS-1:0] out_start_y;
		logic signed [COORD_BITS-1:0] out_end_x;
		logic signed [COORD_BITS-1:0] out_end_y;
	} seg_out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] xmin;
		logic signed [COORD_BITS-1:0] xmax;
		logic signed [COORD_BITS-1:0] ymin;
		logic signed [COORD_BITS-1:0] ymax;
	} window_t;

	// segment as it travels down the pipe
	typedef struct packed {
		seg_in_t pt;
		seg_in_t org;
		logic    rej;
		logic    clp;
	} item_t;

	// edge cut terms: u = a / c, delta magnitude b
	typedef struct packed {
		logic                cut;
		logic                mv_start;
		logic                neg;
		logic [MAG_BITS-1:0] a;
		logic [MAG_BITS-1:0] b;
		logic [MAG_BITS-1:0] c;
	} cut_t;

	function automatic logic [MAG_BITS-1:0] abs_mag(input logic signed [COORD_BITS:0] v);
		logic [COORD_BITS:0] t;
		t = v[COORD_BITS] ? (~v + 1'b1) : v;
		return t[MAG_BITS-1:0];
	endfunction

	// both endpoints beyond the same window edge
	function automatic logic seg_rejected(input seg_in_t p, input window_t w);
		return (p.start_x < w.xmin && p.end_x < w.xmin) ||
			(p.start_x > w.xmax && p.end_x > w.xmax) ||
			(p.start_y > w.ymax && p.end_y > w.ymax) ||
			(p.start_y < w.ymin && p.end_y < w.ymin);
	endfunction

endpackage

/* hw/rtl/line_segment_window_clipper.sv */
// Top level of the pipelined line segment window clipper
//
//   channel  handshake          payload           direction
//   input    start / busy       seg (seg_in_t)    in
//   result   done (strobe)      res (seg_out_t)   out
//   config   cfg_we             cfg_idx, cfg_data in
//
// One item enters per clock; busy stays high until the first edge after reset,
// then low for good.
// done rises once an item has passed the entry register, the left, right, bottom
// and top edges and the result register, and the result is taken at the next edge;
// each edge spends one stage per quotient bit in its divider, which sets the
// depth.
// Reset clears the valid bits and loads the default window (-100..100).
// The receiver cannot stall; every result is shown for one cycle only.
`include "line_segment_window_clipper_assert.svh"
module line_segment_window_clipper (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  lswc_pkg::seg_in_t                      seg,
	output logic                                   done,
	output lswc_pkg::seg_out_t                     res,
	input  logic                                   cfg_we,
	input  logic [lswc_pkg::REG_IDX_BITS-1:0]      cfg_idx,
	input  logic signed [lswc_pkg::COORD_BITS-1:0] cfg_data
);
	import lswc_pkg::*;

	// corner registers, ordered into the window in the cycle after a write
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
	window_t win_q;
	logic    busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= CORNER_A_RST;
			ay_q <= CORNER_A_RST;
			bx_q <= CORNER_B_RST;
			by_q <= CORNER_B_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CORNER_A_X: ax_q <= cfg_data;
				REG_CORNER_A_Y: ay_q <= cfg_data;
				REG_CORNER_B_X: bx_q <= cfg_data;
				REG_CORNER_B_Y: by_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.xmin <= CORNER_A_RST;
			win_q.xmax <= CORNER_B_RST;
			win_q.ymin <= CORNER_A_RST;
			win_q.ymax <= CORNER_B_RST;
			busy_q     <= 1'b1;
		end else begin
			win_q.xmin <= (ax_q < bx_q) ? ax_q : bx_q;
			win_q.xmax <= (ax_q < bx_q) ? bx_q : ax_q;
			win_q.ymin <= (ay_q < by_q) ? ay_q : by_q;
			win_q.ymax <= (ay_q < by_q) ? by_q : ay_q;
			// hold off the first cycle after reset, then accept every cycle
			busy_q     <= 1'b0;
		end
	end

	assign busy = busy_q;

	// entry register: keep the original coordinates for the reject path
	logic  v_s0;
	item_t item_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= start & ~busy_q;
		end
	end

	always_ff @(posedge clk) begin
		item_s0.pt  <= seg;
		item_s0.org <= seg;
		item_s0.rej <= 1'b0;
		item_s0.clp <= 1'b0;
	end

	// left, right, bottom, top in that order
	logic  ev [5];
	item_t ei [5];

	assign ev[0] = v_s0;
	assign ei[0] = item_s0;

	lswc_edge #(.EDGE(EDGE_LEFT)) u_left (
		.clk(clk), .arst_n(arst_n), .win(win_q),
		.in_valid(ev[0]), .in_item(ei[0]), .out_valid(ev[1]), .out_item(ei[1])
	);
	lswc_edge #(.EDGE(EDGE_RIGHT)) u_right (
		.clk(clk), .arst_n(arst_n), .win(win_q),
		.in_valid(ev[1]), .in_item(ei[1]), .out_valid(ev[2]), .out_item(ei[2])
	);
	lswc_edge #(.EDGE(EDGE_BOTTOM)) u_bottom (
		.clk(clk), .arst_n(arst_n), .win(win_q),
		.in_valid(ev[2]), .in_item(ei[2]), .out_valid(ev[3]), .out_item(ei[3])
	);
	lswc_edge #(.EDGE(EDGE_TOP)) u_top (
		.clk(clk), .arst_n(arst_n), .win(win_q),
		.in_valid(ev[3]), .in_item(ei[3]), .out_valid(ev[4]), .out_item(ei[4])
	);

	lswc_out u_out (
		.clk(clk), .arst_n(arst_n), .win(win_q),
		.in_valid(ev[4]), .in_item(ei[4]), .done(done), .res(res)
	);

	// every accepted item strobes once, a fixed number of edges later
	`LSWC_ASSERT(a_fixed_latency, clk, arst_n, done == $past(start && !busy, LATENCY), "result strobe does not match accept")
	// an unclipped result carries the accepted coordinates unchanged
	`LSWC_ASSERT_IMP(a_unclipped_passes, clk, arst_n, done && !res.clipped, res.out_start_x == $past(seg.start_x, LATENCY) && res.out_end_y == $past(seg.end_y, LATENCY), "unclipped result differs from input")
	// a clip mark only on a visible segment
	`LSWC_ASSERT_IMP(a_clip_visible, clk, arst_n, done && res.clipped, res.visible, "clipped result marked invisible")

endmodule

/* hw/rtl/lswc_edge.sv */
// One clipping edge: reject test, cut setup, multiply, pipelined divide, apply
module lswc_edge #(
	parameter lswc_pkg::edge_t EDGE = lswc_pkg::EDGE_LEFT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lswc_pkg::window_t win,
	input  logic              in_valid,
	input  lswc_pkg::item_t   in_item,
	output logic              out_valid,
	output lswc_pkg::item_t   out_item
);
	import lswc_pkg::*;

	localparam logic IS_Y   = (EDGE == EDGE_BOTTOM) || (EDGE == EDGE_TOP);
	localparam logic IS_MAX = (EDGE == EDGE_RIGHT) || (EDGE == EDGE_TOP);
	localparam int   N      = COORD_BITS;

	// setup stage
	logic signed [N-1:0] bound, c0, c1, o0, o1, bound_a, o0_a;
	logic signed [N:0]   num, den, db;
	logic [MAG_BITS-1:0] mag_num, mag_den;
	logic                rej_now;
	item_t               item_d;
	cut_t                cut_d;

	always_comb begin
		rej_now = in_item.rej | seg_rejected(in_item.pt, win);
		if (IS_Y) begin
			bound = IS_MAX ? win.ymax : win.ymin;
			c0 = in_item.pt.start_y;
			c1 = in_item.pt.end_y;
			o0 = in_item.pt.start_x;
			o1 = in_item.pt.end_x;
		end else begin
			bound = IS_MAX ? win.xmax : win.xmin;
			c0 = in_item.pt.start_x;
			c1 = in_item.pt.end_x;
			o0 = in_item.pt.start_y;
			o1 = in_item.pt.end_y;
		end
		num = {bound[N-1], bound} - {c0[N-1], c0};
		den = {c1[N-1], c1} - {c0[N-1], c0};
		db  = {o1[N-1], o1} - {o0[N-1], o0};
		mag_num = abs_mag(num);
		mag_den = abs_mag(den);
		cut_d.cut = !rej_now && (den != '0) && (num != '0) &&
			(num[N] == den[N]) && (mag_num < mag_den);
		cut_d.mv_start = IS_MAX ? (c0 > c1) : (c0 < c1);
		cut_d.neg = db[N];
		cut_d.a = mag_num;
		cut_d.b = abs_mag(db);
		cut_d.c = mag_den;
		item_d = in_item;
		item_d.rej = rej_now;
	end

	logic                 v_s1, v_s2, v_s3;
	item_t                item_s1, item_s2, item_s3;
	cut_t                 cut_s1, cut_s2, cut_s3;
	logic [PROD_BITS-1:0] prod_s2;
	logic [REM_BITS-1:0]  rem_s3;
	logic [MAG_BITS-1:0]  k_s2;

	always_comb begin
		k_s2 = cut_s2.neg ? (cut_s2.c - 1'b1) : cut_s2.c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_d;
		cut_s1  <= cut_d;
		item_s2 <= item_s1;
		cut_s2  <= cut_s1;
		prod_s2 <= cut_s1.a * cut_s1.b;
		item_s3 <= item_s2;
		cut_s3  <= cut_s2;
		rem_s3  <= REM_BITS'({prod_s2, 1'b0}) + REM_BITS'(k_s2);
	end

	// restoring divider, one quotient bit per stage, MSB first
	logic                v_sd    [QUO_BITS];
	item_t               item_sd [QUO_BITS];
	cut_t                cut_sd  [QUO_BITS];
	logic [REM_BITS-1:0] rem_sd  [QUO_BITS];
	logic [QUO_BITS-1:0] quo_sd  [QUO_BITS];

	genvar j;
	for (j = 0; j < QUO_BITS; j++) begin : g_div
		localparam int SH = QUO_BITS - 1 - j;
		logic                v_in;
		item_t               item_in;
		cut_t                cut_in;
		logic [REM_BITS-1:0] rem_in, sub;
		logic [QUO_BITS-1:0] quo_in, quo_nx;
		logic [REM_BITS-1:0] rem_nx;

		if (j == 0) begin : g_first
			assign v_in    = v_s3;
			assign item_in = item_s3;
			assign cut_in  = cut_s3;
			assign rem_in  = rem_s3;
			assign quo_in  = '0;
		end else begin : g_next
			assign v_in    = v_sd[j-1];
			assign item_in = item_sd[j-1];
			assign cut_in  = cut_sd[j-1];
			assign rem_in  = rem_sd[j-1];
			assign quo_in  = quo_sd[j-1];
		end

		always_comb begin
			sub = REM_BITS'({cut_in.c, 1'b0}) << SH;
			rem_nx = rem_in;
			quo_nx = quo_in;
			if (rem_in >= sub) begin
				rem_nx = rem_in - sub;
				quo_nx[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j] <= 1'b0;
			end else begin
				v_sd[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			item_sd[j] <= item_in;
			cut_sd[j]  <= cut_in;
			rem_sd[j]  <= rem_nx;
			quo_sd[j]  <= quo_nx;
		end
	end

	// apply stage: move the outside endpoint onto the edge
	item_t             item_a;
	cut_t              cut_a;
	logic [QUO_BITS-1:0] quo_a;
	logic signed [N:0] res_a;
	logic signed [N-1:0] v_new;

	always_comb begin
		item_a = item_sd[QUO_BITS-1];
		cut_a  = cut_sd[QUO_BITS-1];
		quo_a  = quo_sd[QUO_BITS-1];
		if (IS_Y) begin
			bound_a = IS_MAX ? win.ymax : win.ymin;
			o0_a = item_a.pt.start_x;
		end else begin
			bound_a = IS_MAX ? win.xmax : win.xmin;
			o0_a = item_a.pt.start_y;
		end
		if (cut_a.neg) begin
			res_a = {o0_a[N-1], o0_a} - {1'b0, quo_a};
		end else begin
			res_a = {o0_a[N-1], o0_a} + {1'b0, quo_a};
		end
		v_new = res_a[N-1:0];
		if (cut_a.cut) begin
			item_a.clp = 1'b1;
			if (cut_a.mv_start) begin
				item_a.pt.start_x = IS_Y ? v_new : bound_a;
				item_a.pt.start_y = IS_Y ? bound_a : v_new;
			end else begin
				item_a.pt.end_x = IS_Y ? v_new : bound_a;
				item_a.pt.end_y = IS_Y ? bound_a : v_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_sd[QUO_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		out_item <= item_a;
	end

endmodule

/* hw/rtl/lswc_out.sv */
// Final reject test and result register
module lswc_out (
	input  logic               clk,
	input  logic               arst_n,
	input  lswc_pkg::window_t  win,
	input  logic               in_valid,
	input  lswc_pkg::item_t    in_item,
	output logic               done,
	output lswc_pkg::seg_out_t res
);
	import lswc_pkg::*;

	logic     rej;
	seg_in_t  sel;
	seg_out_t res_d;

	always_comb begin
		rej = in_item.rej | seg_rejected(in_item.pt, win);
		// drop any cuts of a rejected segment
		sel = rej ? in_item.org : in_item.pt;
		res_d.visible     = !rej;
		res_d.clipped     = in_item.clp & !rej;
		res_d.out_start_x = sel.start_x;
		res_d.out_start_y = sel.start_y;
		res_d.out_end_x   = sel.end_x;
		res_d.out_end_y   = sel.end_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res <= res_d;
	end

endmodule
